// File: design/integer_matrix_multiply_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer matrix multiply checker
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_MULTIPLY_ASSERT_SVH
`define INTEGER_MATRIX_MULTIPLY_ASSERT_SVH

// antecedent holds in the same cycle as the consequent
`define IMM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent is checked in the cycle after the antecedent
`define IMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/imm_pkg.sv
// ----------------------------------------------------------------------------
// imm_pkg
// Shared widths, codes and types of the integer matrix multiply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package imm_pkg;

  localparam int unsigned MAX_DIM_DEF = 8;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned ROW_W       = 3;
  localparam int unsigned COL_W       = 3;
  localparam int unsigned CFG_W       = 4;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE_A = 2'd0,
    CMD_WRITE_B = 2'd1,
    CMD_START   = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CMD_W-1:0]         cmd;
    logic [ROW_W-1:0]         row_index;
    logic [COL_W-1:0]         col_index;
    logic signed [DATA_W-1:0] element_value;
  } imm_in_t;

  typedef struct packed {
    logic [ROW_W-1:0]         out_row;
    logic [COL_W-1:0]         out_col;
    logic signed [DATA_W-1:0] product_value;
    logic                     last_element;
  } imm_out_t;

  // tags that travel with each operand read through the MAC pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: design/imm_stream_if.sv
// ----------------------------------------------------------------------------
// imm_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface imm_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

`default_nettype wire

// File: design/imm_store.sv
// ----------------------------------------------------------------------------
// imm_store
// Element memories for matrices A and B, one write and one registered read each.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imm_store #(
  parameter int unsigned MaxDim = imm_pkg::MAX_DIM_DEF,
  parameter int unsigned AddrW  = (MaxDim > 1) ? $clog2(MaxDim * MaxDim) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        wr_a_i,
  input  wire logic                        wr_b_i,
  input  wire logic [AddrW-1:0]            wr_addr_i,
  input  wire logic [imm_pkg::DATA_W-1:0]  wr_data_i,
  input  wire logic                        rd_en_i,
  input  wire logic [AddrW-1:0]            rd_addr_a_i,
  input  wire logic [AddrW-1:0]            rd_addr_b_i,
  output      logic [imm_pkg::DATA_W-1:0]  a_data_o,
  output      logic [imm_pkg::DATA_W-1:0]  b_data_o
);

  import imm_pkg::*;

  localparam int unsigned Depth = MaxDim * MaxDim;

  logic [DATA_W-1:0] mem_a [Depth];
  logic [DATA_W-1:0] mem_b [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_a_i) begin
      mem_a[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      a_data_o <= mem_a[rd_addr_a_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b_i) begin
      mem_b[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      b_data_o <= mem_b[rd_addr_b_i];
    end
  end

endmodule

`default_nettype wire

// File: design/imm_mac.sv
// ----------------------------------------------------------------------------
// imm_mac
// Multiply-accumulate pipeline: align, multiply, accumulate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imm_mac (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire imm_pkg::mac_ctl_t           issue_i,
  input  wire logic [imm_pkg::DATA_W-1:0]  a_data_i,
  input  wire logic [imm_pkg::DATA_W-1:0]  b_data_i,
  output      logic [imm_pkg::DATA_W-1:0]  acc_o,
  output      logic                        done_o
);

  import imm_pkg::*;

  mac_ctl_t          s1_q, s2_q;
  logic [DATA_W-1:0] prod_q, prod_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic              done_q, done_d;

  // low half of the product is the same for signed and unsigned operands
  assign prod_d = a_data_i * b_data_i;

  always_comb begin
    acc_d  = acc_q;
    done_d = 1'b0;
    if (s2_q.valid) begin
      acc_d  = s2_q.first ? prod_q : acc_q + prod_q;
      done_d = s2_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= '0;
      s2_q   <= '0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= issue_i;
      s2_q   <= s1_q;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// File: design/imm_ctrl.sv
// ----------------------------------------------------------------------------
// imm_ctrl
// Config registers, load handling, sweep sequencer and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imm_ctrl #(
  parameter int unsigned MaxDim = imm_pkg::MAX_DIM_DEF,
  parameter int unsigned AddrW  = (MaxDim > 1) ? $clog2(MaxDim * MaxDim) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [imm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [imm_pkg::CFG_W-1:0]     cfg_wdata_i,
  imm_stream_if.sink                         in_i,
  imm_stream_if.source                       out_o,
  output      logic                          wr_a_o,
  output      logic                          wr_b_o,
  output      logic [AddrW-1:0]              wr_addr_o,
  output      logic [imm_pkg::DATA_W-1:0]    wr_data_o,
  output      logic                          rd_en_o,
  output      logic [AddrW-1:0]              rd_addr_a_o,
  output      logic [AddrW-1:0]              rd_addr_b_o,
  output      imm_pkg::mac_ctl_t             issue_o,
  input  wire logic [imm_pkg::DATA_W-1:0]    acc_i,
  input  wire logic                          done_i
);

  import imm_pkg::*;

  localparam int unsigned IdxW = (MaxDim > 1) ? $clog2(MaxDim) : 1;
  localparam int unsigned CmpW = CFG_W + 1;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_WAIT  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_e;

  // effective last index: zero counts as one, oversize clamps to MaxDim
  function automatic logic [IdxW-1:0] last_idx(logic [CFG_W-1:0] r);
    logic [CmpW-1:0] v;
    v = {1'b0, r};
    if (v == '0) begin
      v = CmpW'(1);
    end else if (v > CmpW'(MaxDim)) begin
      v = CmpW'(MaxDim);
    end
    return IdxW'(v - CmpW'(1));
  endfunction

  state_e            state_q, state_d;
  logic [CFG_W-1:0]  rows_q, inner_q, cols_q;
  logic [IdxW-1:0]   r_q, r_d, c_q, c_d, k_q, k_d;
  logic [IdxW-1:0]   lim_r, lim_k, lim_c;
  logic              out_valid_q, out_valid_d;
  imm_out_t          out_data_q, out_data_d;
  logic              in_ready, in_xfer, in_range, last_elem;

  assign lim_r = last_idx(rows_q);
  assign lim_k = last_idx(inner_q);
  assign lim_c = last_idx(cols_q);

  assign in_ready = (state_q == S_IDLE);
  assign in_xfer  = in_i.valid && in_ready;
  assign in_range = (int'(in_i.data.row_index) < MaxDim) &&
                    (int'(in_i.data.col_index) < MaxDim);

  assign wr_a_o    = in_xfer && in_range && (in_i.data.cmd == CMD_WRITE_A);
  assign wr_b_o    = in_xfer && in_range && (in_i.data.cmd == CMD_WRITE_B);
  assign wr_addr_o = AddrW'(in_i.data.row_index) * AddrW'(MaxDim) +
                     AddrW'(in_i.data.col_index);
  assign wr_data_o = in_i.data.element_value;

  assign rd_addr_a_o = AddrW'(r_q) * AddrW'(MaxDim) + AddrW'(k_q);
  assign rd_addr_b_o = AddrW'(k_q) * AddrW'(MaxDim) + AddrW'(c_q);
  assign rd_en_o     = issue_o.valid;

  assign last_elem = (r_q == lim_r) && (c_q == lim_c);

  always_comb begin
    state_d     = state_q;
    r_d         = r_q;
    c_d         = c_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && !out_o.ready;
    out_data_d  = out_data_q;
    issue_o     = '0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && (in_i.data.cmd == CMD_START)) begin
          r_d     = '0;
          c_d     = '0;
          k_d     = '0;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        issue_o.valid = 1'b1;
        issue_o.first = (k_q == '0);
        issue_o.last  = (k_q == lim_k);
        if (k_q == lim_k) begin
          state_d = S_WAIT;
        end else begin
          k_d = k_q + IdxW'(1);
        end
      end
      S_WAIT: begin
        if (done_i) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free or drains this cycle
        if (!out_valid_q || out_o.ready) begin
          out_valid_d                = 1'b1;
          out_data_d.out_row         = ROW_W'(r_q);
          out_data_d.out_col         = COL_W'(c_q);
          out_data_d.product_value   = acc_i;
          out_data_d.last_element    = last_elem;
          k_d                        = '0;
          if (last_elem) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_ISSUE;
            if (c_q == lim_c) begin
              c_d = '0;
              r_d = r_q + IdxW'(1);
            end else begin
              c_d = c_q + IdxW'(1);
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      r_q         <= '0;
      c_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      rows_q      <= CFG_W'(1);
      inner_q     <= CFG_W'(1);
      cols_q      <= CFG_W'(1);
    end else begin
      state_q     <= state_d;
      r_q         <= r_d;
      c_q         <= c_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROWS_A:    rows_q  <= cfg_wdata_i;
          CFG_INNER_DIM: inner_q <= cfg_wdata_i;
          CFG_COLS_B:    cols_q  <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

`default_nettype wire

// File: design/integer_matrix_multiply.sv
// ----------------------------------------------------------------------------
// integer_matrix_multiply
// Signed 32-bit dense matrix multiply over element memories for A and B.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                        | transfer
//  in_i     | in  | cmd, row_index, col_index, element_value       | valid & ready
//  out_o    | out | out_row, out_col, product_value, last_element  | valid & ready
//  cfg      | in  | cfg_idx_i, cfg_wdata_i                         | cfg_we_i
//
//  Load items are taken back to back, one per cycle, while the block is idle.
//  A start holds in_i.ready low for the whole sweep: each product element
//  reads one A/B pair per cycle through the single read port of each memory,
//  then drains the 3-stage MAC before reaching the output reg.
//  A stalled output holds the sweep; once the last element is registered the
//  block takes new items while it waits. Reset gives dims of 1, memories
//  keep their contents undefined until written.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_matrix_multiply #(
  parameter int unsigned MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [imm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [imm_pkg::CFG_W-1:0]     cfg_wdata_i,
  imm_stream_if.sink                         in_i,
  imm_stream_if.source                       out_o
);

  import imm_pkg::*;

  localparam int unsigned AddrW = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

  logic              wr_a, wr_b, rd_en, done;
  logic [AddrW-1:0]  wr_addr, rd_addr_a, rd_addr_b;
  logic [DATA_W-1:0] wr_data, a_data, b_data, acc;
  mac_ctl_t          issue;

  imm_ctrl #(
    .MaxDim (MAX_DIM),
    .AddrW  (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .wr_a_o      (wr_a),
    .wr_b_o      (wr_b),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_en_o     (rd_en),
    .rd_addr_a_o (rd_addr_a),
    .rd_addr_b_o (rd_addr_b),
    .issue_o     (issue),
    .acc_i       (acc),
    .done_i      (done)
  );

  imm_store #(
    .MaxDim (MAX_DIM),
    .AddrW  (AddrW)
  ) u_store (
    .clk_i       (clk_i),
    .wr_a_i      (wr_a),
    .wr_b_i      (wr_b),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_en_i     (rd_en),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .a_data_o    (a_data),
    .b_data_o    (b_data)
  );

  imm_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (issue),
    .a_data_i (a_data),
    .b_data_i (b_data),
    .acc_o    (acc),
    .done_o   (done)
  );

endmodule

`default_nettype wire

// File: design/imm_checker.sv
// ----------------------------------------------------------------------------
// imm_checker
// Port-level checks of the matrix multiply, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "integer_matrix_multiply_assert.svh"

module imm_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_i,
  input wire logic [imm_pkg::CMD_W-1:0] in_cmd_i,
  input wire logic                      out_valid_i,
  input wire logic                      out_ready_i,
  input wire logic                      out_last_i
);

  import imm_pkg::*;

  logic start_xfer;

  assign start_xfer = in_valid_i && in_ready_i && (in_cmd_i == CMD_START);

  // a start always closes the input for the sweep
  `IMM_ASSERT_NEXT(a_start_blocks, start_xfer, !in_ready_i, "input open after start")

  // results are only produced while the sweep runs
  `IMM_ASSERT_SAME(a_out_in_sweep, $rose(out_valid_i), $past(!in_ready_i), "result outside sweep")

  // input reopens only with the flagged final element in the output register
  `IMM_ASSERT_SAME(a_reopen_last, $rose(in_ready_i), out_valid_i && out_last_i,
                   "input reopened before final element")

  `IMM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i,
                   "result dropped while stalled")

endmodule

bind integer_matrix_multiply imm_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_cmd_i    (in_i.data.cmd),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_last_i  (out_o.data.last_element)
);

`default_nettype wire

// File: verif/imm_product_checker.sv
// ----------------------------------------------------------------------------
// imm_product_checker
// Watches the load/start channel, the product channel and the dimension
// writes. Keeps its own copy of both element stores and the dimensions,
// works out every product element when a start is taken and compares each
// product transfer, field by field, with the oldest element still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module imm_product_checker
  import imm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  imm_in_t              in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  imm_out_t             out_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output int unsigned          mismatch_count_o,
  output int unsigned          products_pending_o
);

  logic [DATA_W-1:0] a_elem [MAX_DIM_DEF][MAX_DIM_DEF];
  logic [DATA_W-1:0] b_elem [MAX_DIM_DEF][MAX_DIM_DEF];
  logic [CFG_W-1:0]  rows_q;
  logic [CFG_W-1:0]  inner_q;
  logic [CFG_W-1:0]  cols_q;
  imm_out_t          owed_products [$];
  int unsigned       mismatches = 0;

  assign mismatch_count_o   = mismatches;
  assign products_pending_o = owed_products.size();

  // 0 behaves as 1, anything past the array size as the array size
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(v);
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] MISMATCH %s", $realtime, msg);
  endtask

  // row-major sweep of the product; sums wrap at 32 bits
  task automatic queue_products();
    int unsigned       nr;
    int unsigned       nk;
    int unsigned       nc;
    logic [DATA_W-1:0] acc;
    imm_out_t          elem;
    nr = clamp_dim(rows_q);
    nk = clamp_dim(inner_q);
    nc = clamp_dim(cols_q);
    for (int unsigned r = 0; r < nr; r++) begin
      for (int unsigned c = 0; c < nc; c++) begin
        acc = '0;
        for (int unsigned k = 0; k < nk; k++) begin
          acc = acc + a_elem[r][k] * b_elem[k][c];
        end
        elem.out_row       = ROW_W'(r);
        elem.out_col       = COL_W'(c);
        elem.product_value = acc;
        elem.last_element  = (r + 1 == nr) && (c + 1 == nc);
        owed_products.push_back(elem);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    imm_out_t owed;
    if (!rst_ni) begin
      rows_q  = CFG_W'(1);
      inner_q = CFG_W'(1);
      cols_q  = CFG_W'(1);
      owed_products.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROWS_A:    rows_q  = cfg_wdata_i;
          CFG_INNER_DIM: inner_q = cfg_wdata_i;
          CFG_COLS_B:    cols_q  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (owed_products.size() == 0) begin
          report_mismatch($sformatf("unexpected product (%0d,%0d) %0d last %0b",
                                    out_data_i.out_row, out_data_i.out_col,
                                    out_data_i.product_value, out_data_i.last_element));
        end else begin
          owed = owed_products.pop_front();
          if (out_data_i.out_row !== owed.out_row ||
              out_data_i.out_col !== owed.out_col ||
              out_data_i.product_value !== owed.product_value ||
              out_data_i.last_element !== owed.last_element) begin
            report_mismatch($sformatf(
              "got (%0d,%0d) %0d last %0b, want (%0d,%0d) %0d last %0b",
              out_data_i.out_row, out_data_i.out_col, out_data_i.product_value,
              out_data_i.last_element, owed.out_row, owed.out_col,
              owed.product_value, owed.last_element));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (in_data_i.cmd)
          CMD_WRITE_A: a_elem[in_data_i.row_index][in_data_i.col_index] = in_data_i.element_value;
          CMD_WRITE_B: b_elem[in_data_i.row_index][in_data_i.col_index] = in_data_i.element_value;
          CMD_START:   queue_products();
          default: ;
        endcase
      end
    end
  end

endmodule

// File: verif/tb_integer_matrix_multiply.sv
// ----------------------------------------------------------------------------
// tb_integer_matrix_multiply
// Loads A and B elements and starts multiplies over a range of dimension
// settings, with bursty loads and a stalling product sink. Checking is done
// by imm_product_checker; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_integer_matrix_multiply;
  import imm_pkg::*;

  localparam int unsigned      CLK_HALF      = 4;
  localparam int unsigned      ITEM_TARGET   = 310;
  localparam int unsigned      STALL_LIMIT   = 2000;
  localparam int unsigned      SETTLE_CYCLES = 16;
  localparam logic [CMD_W-1:0] CMD_UNUSED    = 2'd3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  int unsigned          mismatches;
  int unsigned          products_pending;
  bit                   a_loaded [MAX_DIM_DEF][MAX_DIM_DEF];
  bit                   b_loaded [MAX_DIM_DEF][MAX_DIM_DEF];
  int unsigned          items_sent;
  int unsigned          burst_left;
  int unsigned          dim_r;
  int unsigned          dim_k;
  int unsigned          dim_c;

  imm_stream_if #(.payload_t(imm_in_t))  in_if ();
  imm_stream_if #(.payload_t(imm_out_t)) out_if ();

  integer_matrix_multiply u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  imm_product_checker u_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_if.valid),
    .in_ready_i         (in_if.ready),
    .in_data_i          (in_if.data),
    .out_valid_i        (out_if.valid),
    .out_ready_i        (out_if.ready),
    .out_data_i         (out_if.data),
    .cfg_we_i           (cfg_we),
    .cfg_idx_i          (cfg_idx),
    .cfg_wdata_i        (cfg_wdata),
    .mismatch_count_o   (mismatches),
    .products_pending_o (products_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // product sink: segments of always-ready, random and stalled
  initial begin
    int unsigned seg;
    int unsigned mode;
    seg  = 0;
    mode = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (seg == 0) begin
        mode = $urandom_range(0, 3);
        seg  = (mode == 3) ? $urandom_range(3, 20) : $urandom_range(4, 40);
      end
      seg--;
      case (mode)
        0:       out_if.ready = 1'b1;
        1:       out_if.ready = 1'($urandom_range(0, 1));
        2:       out_if.ready = ($urandom_range(0, 3) != 0);
        default: out_if.ready = 1'b0;
      endcase
    end
  end

  // watchdog: too long without any transfer ends the run
  initial begin
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("integer_matrix_multiply test failed");
    $finish;
  end

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
    return int'(v);
  endfunction

  function automatic logic [DATA_W-1:0] random_element();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    case (pick)
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return '0;
      4, 5, 6, 7, 8, 9: return DATA_W'($signed($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  // mostly small sizes; 0 and values past the array size now and then
  function automatic logic [CFG_W-1:0] random_dim();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0:       return '0;
      1:       return CFG_W'(MAX_DIM_DEF);
      2:       return CFG_W'($urandom_range(MAX_DIM_DEF + 1, 15));
      default: return CFG_W'($urandom_range(1, 3));
    endcase
  endfunction

  // one transfer on the load/start channel, inside bursts with random gaps
  task automatic send_item(input imm_in_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      in_if.valid = 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    in_if.valid = 1'b1;
    in_if.data  = it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    in_if.valid = 1'b0;
    burst_left--;
    if (it.cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic load_element(input logic [CMD_W-1:0] which, input int unsigned row,
                              input int unsigned col, input logic [DATA_W-1:0] value);
    imm_in_t it;
    it.cmd           = which;
    it.row_index     = ROW_W'(row);
    it.col_index     = COL_W'(col);
    it.element_value = value;
    if (which == CMD_WRITE_A) a_loaded[row][col] = 1'b1;
    else b_loaded[row][col] = 1'b1;
    send_item(it);
  endtask

  task automatic send_unused();
    imm_in_t it;
    it.cmd           = CMD_UNUSED;
    it.row_index     = ROW_W'($urandom);
    it.col_index     = COL_W'($urandom);
    it.element_value = $urandom;
    send_item(it);
  endtask

  // entries the sweep will read must have been loaded first
  task automatic start_multiply();
    imm_in_t it;
    for (int unsigned r = 0; r < dim_r; r++)
      for (int unsigned k = 0; k < dim_k; k++)
        if (!a_loaded[r][k]) load_element(CMD_WRITE_A, r, k, random_element());
    for (int unsigned k = 0; k < dim_k; k++)
      for (int unsigned c = 0; c < dim_c; c++)
        if (!b_loaded[k][c]) load_element(CMD_WRITE_B, k, c, random_element());
    it.cmd           = CMD_START;
    it.row_index     = ROW_W'($urandom);
    it.col_index     = COL_W'($urandom);
    it.element_value = $urandom;
    send_item(it);
  endtask

  // dimensions change only once every owed product has been taken
  task automatic set_dims(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
                          input logic [CFG_W-1:0] c);
    while (products_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_idx   = CFG_ROWS_A;
    cfg_wdata = r;
    @(negedge clk_i);
    cfg_idx   = CFG_INNER_DIM;
    cfg_wdata = k;
    @(negedge clk_i);
    cfg_idx   = CFG_COLS_B;
    cfg_wdata = c;
    @(negedge clk_i);
    cfg_we = 1'b0;
    dim_r  = clamp_dim(r);
    dim_k  = clamp_dim(k);
    dim_c  = clamp_dim(c);
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] r, input logic [CFG_W-1:0] k,
                              input logic [CFG_W-1:0] c);
    int unsigned starts;
    int unsigned loads;
    int unsigned pick;
    set_dims(r, k, c);
    starts = ($urandom_range(0, 3) == 0) ? 2 : 1;
    repeat (starts) begin
      loads = $urandom_range(0, 6);
      repeat (loads) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          send_unused();
        end else if (pick < 4) begin
          load_element(pick[0] ? CMD_WRITE_A : CMD_WRITE_B, $urandom_range(0, MAX_DIM_DEF - 1),
                       $urandom_range(0, MAX_DIM_DEF - 1), random_element());
        end else if (pick[0]) begin
          load_element(CMD_WRITE_A, $urandom_range(0, dim_r - 1), $urandom_range(0, dim_k - 1),
                       random_element());
        end else begin
          load_element(CMD_WRITE_B, $urandom_range(0, dim_k - 1), $urandom_range(0, dim_c - 1),
                       random_element());
        end
      end
      start_multiply();
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_ROWS_A;
    cfg_wdata    = '0;
    items_sent   = 0;
    burst_left   = 0;
    dim_r        = 1;
    dim_k        = 1;
    dim_c        = 1;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: wrap of extreme products, ignored start fields, unused
    // command, a store outside the current dimensions
    set_dims(CFG_W'(1), CFG_W'(1), CFG_W'(1));
    load_element(CMD_WRITE_A, 0, 0, 32'h8000_0000);
    load_element(CMD_WRITE_B, 0, 0, 32'h8000_0000);
    start_multiply();
    load_element(CMD_WRITE_A, 0, 0, 32'hFFFF_FFFF);
    load_element(CMD_WRITE_B, 0, 0, 32'h7FFF_FFFF);
    start_multiply();
    send_unused();
    load_element(CMD_WRITE_A, 7, 7, 32'h7FFF_FFFF);
    load_element(CMD_WRITE_B, 7, 7, 32'h8000_0000);
    start_multiply();
    load_element(CMD_WRITE_A, 0, 0, '0);
    start_multiply();

    // out-of-range dimension values at both ends
    random_phase(CFG_W'(15), CFG_W'(0), CFG_W'(15));
    random_phase(CFG_W'(0), CFG_W'(15), CFG_W'(0));
    while (items_sent < ITEM_TARGET) random_phase(random_dim(), random_dim(), random_dim());

    while (products_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("integer_matrix_multiply test passed");
    end else begin
      $display("integer_matrix_multiply test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/imm_pkg.sv
design/imm_stream_if.sv
design/imm_store.sv
design/imm_mac.sv
design/imm_ctrl.sv
design/integer_matrix_multiply.sv
design/imm_checker.sv
verif/imm_product_checker.sv
verif/tb_integer_matrix_multiply.sv
